// File: design/ilut_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_pkg
// Shared types and codes of the interpolating lookup table: register indexes,
// result status codes and fixed field widths.
// ----------------------------------------------------------------------------
package ilut_pkg;

    localparam int DATA_W       = 32;
    localparam int SIDX_W       = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int STATUS_W     = 2;
    localparam int PIPE_LATENCY = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_BOUND    = 3'd0,
        CFG_UPPER_BOUND    = 3'd1,
        CFG_POSITION_SCALE = 3'd2,
        CFG_LAST_INDEX     = 3'd3,
        CFG_TABLE_READY    = 3'd4
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_INTERP     = 2'd0,
        ST_CLAMP_LOW  = 2'd1,
        ST_CLAMP_HIGH = 2'd2,
        ST_NOT_READY  = 2'd3
    } t_status;

endpackage

// File: design/ilut_sample_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_sample_ram
// Sample memory: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ilut_sample_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [ilut_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output logic [ilut_pkg::DATA_W-1:0] o_rdata_a,
    output logic [ilut_pkg::DATA_W-1:0] o_rdata_b
);

    logic [ilut_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: design/interpolating_lookup_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolating_lookup_table
// Piecewise linear interpolation over a table of evenly spaced Q16.16
// samples, with clamping at the bounds and a not-ready status.
// ----------------------------------------------------------------------------
// The block takes one item every clock (busy stays low) and returns the
// result of an evaluate item after it has passed stages 1 to 4, on o_valid for
// a single cycle; a load item returns nothing. The receiver cannot stall the
// output. The rate is set by the sample memory, which serves one write and
// two reads per cycle, so loads and evaluates share it in arrival order.
// Write configuration only while no evaluate is in flight.
// ----------------------------------------------------------------------------
module interpolating_lookup_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ilut_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ilut_pkg::DATA_W-1:0]           i_cfg_wdata,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_func,
    input  logic [ilut_pkg::SIDX_W-1:0]           i_sample_index,
    input  logic signed [ilut_pkg::DATA_W-1:0]    i_sample_value,
    input  logic signed [ilut_pkg::DATA_W-1:0]    i_x_position,
    output logic                                  o_valid,
    output logic signed [ilut_pkg::DATA_W-1:0]    o_y_value,
    output logic [ilut_pkg::STATUS_W-1:0]         o_result_status
);

    localparam int DW = ilut_pkg::DATA_W;
    localparam int SW = ilut_pkg::SIDX_W;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = FRAC_BITS;
    localparam int IW = 2 * DW - 2 * FW;
    localparam int PW = DW + FW + 2;
    localparam logic [PW-1:0] ROUND_HALF = {{(PW-1){1'b0}}, 1'b1} << (FW - 1);

    // configuration
    logic signed [DW-1:0] r_lower_bound;
    logic signed [DW-1:0] r_upper_bound;
    logic [DW-1:0]        r_position_scale;
    logic [SW-1:0]        r_last_index;
    logic                 r_table_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound    <= '0;
            r_upper_bound    <= '0;
            r_position_scale <= '0;
            r_last_index     <= '0;
            r_table_ready    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ilut_pkg::CFG_LOWER_BOUND:    r_lower_bound    <= signed'(i_cfg_wdata);
                ilut_pkg::CFG_UPPER_BOUND:    r_upper_bound    <= signed'(i_cfg_wdata);
                ilut_pkg::CFG_POSITION_SCALE: r_position_scale <= i_cfg_wdata;
                ilut_pkg::CFG_LAST_INDEX:     r_last_index     <= i_cfg_wdata[SW-1:0];
                ilut_pkg::CFG_TABLE_READY:    r_table_ready    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    logic w_accept;
    assign w_accept = start && !busy;

    // stage 1: bound tests and offset
    ilut_pkg::t_status n1_status;
    always_comb begin
        priority if (!r_table_ready) begin
            n1_status = ilut_pkg::ST_NOT_READY;
        end else if (i_x_position <= r_lower_bound) begin
            n1_status = ilut_pkg::ST_CLAMP_LOW;
        end else if (i_x_position >= r_upper_bound) begin
            n1_status = ilut_pkg::ST_CLAMP_HIGH;
        end else begin
            n1_status = ilut_pkg::ST_INTERP;
        end
    end

    logic                 r1_valid;
    logic                 r1_load;
    logic [SW-1:0]        r1_sidx;
    logic [DW-1:0]        r1_svalue;
    logic [DW-1:0]        r1_d;
    ilut_pkg::t_status    r1_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= w_accept;
        end
        r1_load   <= !i_func;
        r1_sidx   <= i_sample_index;
        r1_svalue <= unsigned'(i_sample_value);
        r1_d      <= DW'(unsigned'(i_x_position) - unsigned'(r_lower_bound));
        r1_status <= n1_status;
    end

    // stage 2: scale the offset
    logic                 r2_valid;
    logic                 r2_load;
    logic [SW-1:0]        r2_sidx;
    logic [DW-1:0]        r2_svalue;
    logic [2*DW-1:0]      r2_prod;
    ilut_pkg::t_status    r2_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_load   <= r1_load;
        r2_sidx   <= r1_sidx;
        r2_svalue <= r1_svalue;
        r2_prod   <= (2*DW)'(r1_d) * (2*DW)'(r_position_scale);
        r2_status <= r1_status;
    end

    // stage 2 memory access: loads write, interpolating evaluates read both neighbors
    logic [IW-1:0]        w_idx;
    logic [FW-1:0]        w_frac;
    ilut_pkg::t_status    n2_status;
    logic [SW-1:0]        w_addr_a;
    logic [SW-1:0]        w_addr_b;
    logic                 w_we;
    logic [DW-1:0]        w_rdata_a;
    logic [DW-1:0]        w_rdata_b;

    assign w_idx  = r2_prod[2*DW-1:2*FW];
    assign w_frac = r2_prod[2*FW-1:FW];

    always_comb begin
        n2_status = r2_status;
        if (r2_status == ilut_pkg::ST_INTERP && w_idx >= IW'(r_last_index)) begin
            n2_status = ilut_pkg::ST_CLAMP_HIGH;
        end
        unique case (n2_status)
            ilut_pkg::ST_INTERP: begin
                w_addr_a = w_idx[SW-1:0];
                w_addr_b = SW'(w_idx[SW-1:0] + 1'b1);
            end
            ilut_pkg::ST_CLAMP_HIGH: begin
                w_addr_a = r_last_index;
                w_addr_b = r_last_index;
            end
            default: begin
                w_addr_a = '0;
                w_addr_b = '0;
            end
        endcase
    end

    assign w_we = r2_valid && r2_load && (DW'(r2_sidx) < DW'(TABLE_DEPTH));

    ilut_sample_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (AW'(r2_sidx)),
        .i_wdata   (r2_svalue),
        .i_raddr_a (AW'(w_addr_a)),
        .i_raddr_b (AW'(w_addr_b)),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    logic                 r3_valid;
    ilut_pkg::t_status    r3_status;
    logic [FW-1:0]        r3_frac;
    logic                 r3_oob_a;
    logic                 r3_oob_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid && !r2_load;
        end
        r3_status <= n2_status;
        r3_frac   <= w_frac;
        r3_oob_a  <= DW'(w_addr_a) >= DW'(TABLE_DEPTH);
        r3_oob_b  <= DW'(w_addr_b) >= DW'(TABLE_DEPTH);
    end

    // stage 3: slope times fraction
    logic signed [DW-1:0] w_y0;
    logic signed [DW-1:0] w_y1;
    logic signed [DW:0]   w_diff;
    logic signed [FW:0]   w_frac_s;
    logic signed [PW-1:0] w_slope;

    assign w_y0     = r3_oob_a ? '0 : signed'(w_rdata_a);
    assign w_y1     = r3_oob_b ? '0 : signed'(w_rdata_b);
    assign w_diff   = (DW+1)'(w_y1) - (DW+1)'(w_y0);
    assign w_frac_s = signed'({1'b0, r3_frac});
    assign w_slope  = w_diff * w_frac_s;

    logic                 r4_valid;
    ilut_pkg::t_status    r4_status;
    logic signed [DW-1:0] r4_y0;
    logic signed [PW-1:0] r4_slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_status <= r3_status;
        r4_y0     <= w_y0;
        r4_slope  <= w_slope;
    end

    // stage 4: round, add and select
    logic signed [PW-1:0] w_sum;
    logic signed [PW-1:0] w_q;
    logic signed [DW-1:0] n_out_y;

    assign w_sum = r4_slope + signed'(ROUND_HALF);
    assign w_q   = w_sum >>> FW;

    always_comb begin
        unique case (r4_status)
            ilut_pkg::ST_NOT_READY: n_out_y = '0;
            ilut_pkg::ST_INTERP:    n_out_y = DW'(r4_y0 + w_q[DW-1:0]);
            default:                n_out_y = r4_y0;
        endcase
    end

    logic                 r_out_valid;
    logic signed [DW-1:0] r_out_y;
    ilut_pkg::t_status    r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r4_valid;
        end
        r_out_y      <= n_out_y;
        r_out_status <= r4_status;
    end

    assign o_valid         = r_out_valid;
    assign o_y_value       = r_out_y;
    assign o_result_status = r_out_status;

endmodule

// File: design/ilut_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_checker
// Port-level checks of the interpolating lookup table: fixed result latency,
// no busy stall and a zero value on a not-ready result.
// ----------------------------------------------------------------------------
module ilut_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               i_func,
    input logic                               o_valid,
    input logic signed [ilut_pkg::DATA_W-1:0] o_y_value,
    input logic [ilut_pkg::STATUS_W-1:0]      o_result_status
);

    localparam int LAT = ilut_pkg::PIPE_LATENCY;

    logic w_eval;
    assign w_eval = start && !busy && i_func;

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_eval, LAT))
        else $error("result without an evaluate transfer");

    a_eval_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_eval, LAT) && $past(i_rst_n, 1) && $past(i_rst_n, 2) &&
         $past(i_rst_n, 3) && $past(i_rst_n, 4) && $past(i_rst_n, LAT)) |-> o_valid)
        else $error("evaluate transfer lost");

    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_status == ilut_pkg::ST_NOT_READY) |-> o_y_value == '0)
        else $error("not-ready result carries a value");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind interpolating_lookup_table ilut_checker u_ilut_checker (.*);
